// File: rtl/masked_byte_pattern_search_core_assert.svh
// Assertion macros used by the masked byte pattern search core RTL.
// Define NO_ASSERTIONS to compile the macros to nothing.
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbps assertion failed");
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbps assertion failed");
`else
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons)
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mbps_pkg.sv
// Package for the masked byte pattern search core: sizes, register codes,
// transaction payload types and per-lane types. No dependencies.
package mbps_pkg;

   localparam int MAX_PATTERN       = 48;
   localparam int OFFSET_BITS       = 32;
   localparam int REG_BYTES         = 48;
   localparam int NUM_PAT_REGS      = 6;
   localparam int LEN_BITS          = $clog2(MAX_PATTERN + 1);
   localparam int LENGTH_REG_BITS   = 6;
   localparam int CARE_REG_BITS     = 48;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_ADDR_BITS     = CSR_INDEX_BITS + 3;
   localparam int OFFSET_FIELD_BITS = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_0      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_5      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CARE_MASK      = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic                         found;
      logic [OFFSET_FIELD_BITS-1:0] match_offset;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] pattern_byte;
      logic       care;
      logic       need;
   } lane_pat_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } lane_ctrl_type;

endpackage

// File: rtl/masked_byte_pattern_search_core.sv
// Masked byte pattern search core: a chain of MAX_PATTERN window lanes
// shifted once per accepted byte, tested in parallel against the aligned
// pattern. One byte per cycle unless the output stalls; the result is
// registered via stage A for the byte ending the match or the region.
// The compare across all lanes and its AND reduction set the cycle time.
// Reset (synchronous): pattern and care cleared, length 1, scan restarted.
module masked_byte_pattern_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mbps_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mbps_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import mbps_pkg::*;
`include "masked_byte_pattern_search_core_assert.svh"

   lane_pat_type [MAX_PATTERN-1:0] lane_pat;
   logic [LEN_BITS-1:0]            len_eff;

   logic [7:0]             lane_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] lane_valid;
   logic [MAX_PATTERN-1:0] lane_ok;

   logic                   a_valid_ff, a_valid_in;
   logic                   a_last_ff;
   logic [OFFSET_BITS-1:0] a_pos_ff;
   logic [OFFSET_BITS-1:0] pos_ff;
   logic                   match_seen_ff, match_seen_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_payload_type        out_payload_ff;

   logic                   req_accept;
   logic                   b_fire;
   logic                   window_match;
   logic                   hit;
   logic                   miss_end;
   logic                   emit;
   logic [OFFSET_BITS-1:0] start_pos;

   mbps_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .lane_pat    (lane_pat),
      .len_eff     (len_eff)
   );

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
      lane_ctrl_type ctrl;
      logic [7:0]    up_byte;
      logic          up_valid;

      if (k == 0) begin : g_head
         assign ctrl.shift = req_accept;
         assign ctrl.clear = 1'b0;
         assign up_byte    = req_payload.data_byte;
         assign up_valid   = 1'b1;
      end else begin : g_body
         assign ctrl.shift = req_accept;
         assign ctrl.clear = a_last_ff;
         assign up_byte    = lane_byte[k-1];
         assign up_valid   = lane_valid[k-1];
      end

      mbps_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .up_byte   (up_byte),
         .up_valid  (up_valid),
         .pat       (lane_pat[k]),
         .byte_out  (lane_byte[k]),
         .valid_out (lane_valid[k]),
         .ok        (lane_ok[k])
      );
   end

   assign b_fire     = a_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !reset && (!a_valid_ff || b_fire);
   assign req_accept = req_valid && req_ready;

   assign window_match = &lane_ok;
   assign hit          = window_match && !match_seen_ff;
   assign miss_end     = a_last_ff && !match_seen_ff && !window_match;
   assign emit         = b_fire && (hit || miss_end);
   assign start_pos    = a_pos_ff - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (b_fire) begin
         a_valid_in = 1'b0;
      end
      match_seen_in = match_seen_ff;
      if (b_fire) begin
         match_seen_in = a_last_ff ? 1'b0 : (match_seen_ff || hit);
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         a_last_ff     <= 1'b0;
         pos_ff        <= '0;
         match_seen_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         match_seen_ff <= match_seen_in;
         out_valid_ff  <= out_valid_in;
         if (req_accept) begin
            a_last_ff <= req_payload.is_last;
            pos_ff    <= req_payload.is_last ? '0 : pos_ff + OFFSET_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_pos_ff <= pos_ff;
      end
      if (emit) begin
         out_payload_ff.found        <= hit;
         out_payload_ff.match_offset <= hit ? OFFSET_FIELD_BITS'(start_pos) : '0;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   `MBPS_ASSERT_NOW(a_no_result_overwrite, clock, reset, emit, !out_valid_ff || rsp_ready)
   `MBPS_ASSERT_NEXT(a_region_end_clears, clock, reset, b_fire && a_last_ff, !match_seen_ff)
   `MBPS_ASSERT_NEXT(a_hit_sets_seen, clock, reset, b_fire && hit && !a_last_ff, match_seen_ff)
   `MBPS_ASSERT_NOW(a_miss_offset_zero, clock, reset, rsp_valid && !rsp_payload.found, rsp_payload.match_offset == '0)

endmodule

// File: rtl/mbps_regs.sv
// Configuration registers of the masked byte pattern search core (APB-style
// port) and the per-lane pattern alignment. Depends on mbps_pkg.
module mbps_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output mbps_pkg::lane_pat_type [mbps_pkg::MAX_PATTERN-1:0] lane_pat,
   output logic [mbps_pkg::LEN_BITS-1:0]         len_eff
);
   import mbps_pkg::*;

   logic [CSR_DATA_BITS-1:0]   pattern_ff [NUM_PAT_REGS];
   logic [CARE_REG_BITS-1:0]   care_ff;
   logic [LENGTH_REG_BITS-1:0] length_ff;

   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic                       csr_write;

   logic [LEN_BITS-1:0]        len_in;
   logic [LEN_BITS-1:0]        len_ff;
   logic [LEN_BITS-1:0]        shift_bytes;
   logic [MAX_PATTERN*8-1:0]   rev_pat;
   logic [MAX_PATTERN-1:0]     rev_care;
   logic [MAX_PATTERN*8-1:0]   al_pat;
   logic [MAX_PATTERN-1:0]     al_care;
   lane_pat_type [MAX_PATTERN-1:0] lane_pat_in;
   lane_pat_type [MAX_PATTERN-1:0] lane_pat_ff;

   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAT_REGS; i++) begin
            pattern_ff[i] <= '0;
         end
         care_ff   <= '0;
         length_ff <= LENGTH_REG_BITS'(1);
      end else if (csr_write) begin
         case (csr_index) inside
            [REG_PATTERN_0:REG_PATTERN_5]: pattern_ff[csr_index] <= csr_pwdata;
            REG_CARE_MASK:      care_ff   <= csr_pwdata[CARE_REG_BITS-1:0];
            REG_PATTERN_LENGTH: length_ff <= csr_pwdata[LENGTH_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index) inside
         [REG_PATTERN_0:REG_PATTERN_5]: csr_prdata = pattern_ff[csr_index];
         REG_CARE_MASK:      csr_prdata = CSR_DATA_BITS'(care_ff);
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_BITS'(length_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (length_ff == '0) begin
         len_in = LEN_BITS'(1);
      end else if (LEN_BITS'(length_ff) > LEN_BITS'(MAX_PATTERN)) begin
         len_in = LEN_BITS'(MAX_PATTERN);
      end else begin
         len_in = LEN_BITS'(length_ff);
      end
   end

   // Reverse the pattern, then shift so lane k faces pattern byte len-1-k.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (MAX_PATTERN - 1 - i < REG_BYTES) begin
            rev_pat[8*i +: 8] =
               pattern_ff[(MAX_PATTERN-1-i)/8][8*((MAX_PATTERN-1-i)%8) +: 8];
            rev_care[i] = care_ff[MAX_PATTERN-1-i];
         end else begin
            rev_pat[8*i +: 8] = 8'h00;
            rev_care[i]       = 1'b0;
         end
      end
      shift_bytes = LEN_BITS'(MAX_PATTERN) - len_in;
      al_pat      = rev_pat >> {shift_bytes, 3'b000};
      al_care     = rev_care >> shift_bytes;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         lane_pat_in[k].pattern_byte = al_pat[8*k +: 8];
         lane_pat_in[k].care         = al_care[k];
         lane_pat_in[k].need         = (LEN_BITS'(k) < len_in);
      end
   end

   always_ff @(posedge clock) begin
      lane_pat_ff <= lane_pat_in;
      len_ff      <= len_in;
   end

   assign lane_pat = lane_pat_ff;
   assign len_eff  = len_ff;

endmodule

// File: rtl/mbps_lane.sv
// One window lane of the masked byte pattern search core: holds a byte and
// its valid bit, hands both on, and tests them against its pattern byte.
// Depends on mbps_pkg.
module mbps_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  mbps_pkg::lane_ctrl_type ctrl,
   input  logic [7:0]             up_byte,
   input  logic                   up_valid,
   input  mbps_pkg::lane_pat_type pat,
   output logic [7:0]             byte_out,
   output logic                   valid_out,
   output logic                   ok
);
   import mbps_pkg::*;

   logic [7:0] byte_ff;
   logic       valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         byte_ff <= up_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= up_valid && !ctrl.clear;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;
   assign ok = !pat.need || (valid_ff && (!pat.care || (byte_ff == pat.pattern_byte)));

endmodule

// File: sim/tb_top.sv
// Testbench for masked_byte_pattern_search_core: streams byte regions, predicts the
// first-match or not-found transaction per region and checks every result in order.
// Depends on mbps_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbps_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS = 400;
   localparam int LONG_HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   masked_byte_pattern_search_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // register copies
   logic [63:0] pattern_regs [NUM_PAT_REGS] = '{default: '0};
   logic [CARE_REG_BITS-1:0] care_bits = '0;
   logic [LENGTH_REG_BITS-1:0] scan_length = 6'd1;

   // scan state
   logic [7:0] window [MAX_PATTERN] = '{default: '0};
   logic [OFFSET_BITS-1:0] scan_position = '0;
   bit match_seen = 1'b0;
   int window_fill = 0;

   rsp_payload_type match_reports_due [$];
   int error_count = 0;
   bit source_no_gaps = 1'b0;
   bit sink_always_ready = 1'b0;
   int long_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int effective_length();
      int n;
      n = int'(scan_length);
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(int j);
      return pattern_regs[j / 8][(j % 8) * 8 +: 8];
   endfunction

   task automatic scan_next_byte(input req_payload_type item);
      int eff_len;
      bit hit;
      rsp_payload_type report;
      eff_len = effective_length();
      for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = item.data_byte;
      if (window_fill < MAX_PATTERN) window_fill++;
      hit = !match_seen && window_fill >= eff_len;
      for (int j = 0; j < eff_len; j++) begin
         if (care_bits[j] && pattern_byte(j) != window[eff_len - 1 - j]) hit = 1'b0;
      end
      if (hit) begin
         report.found = 1'b1;
         report.match_offset = OFFSET_FIELD_BITS'(scan_position - eff_len + 1);
         match_reports_due.push_back(report);
         match_seen = 1'b1;
      end else if (item.is_last && !match_seen) begin
         report = '0;
         match_reports_due.push_back(report);
      end
      scan_position = scan_position + 1'b1;
      if (item.is_last) begin
         window = '{default: '0};
         scan_position = '0;
         match_seen = 1'b0;
         window_fill = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : result_checker
      rsp_payload_type want;
      if (!reset && req_valid && req_ready) scan_next_byte(req_payload);
      if (!reset && rsp_valid && rsp_ready) begin
         if (match_reports_due.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.match_offset, '0);
         end else begin
            want = match_reports_due.pop_front();
            if (rsp_payload.found !== want.found)
               report_mismatch("found", 32'(rsp_payload.found), 32'(want.found));
            if (rsp_payload.match_offset !== want.match_offset)
               report_mismatch("match_offset", rsp_payload.match_offset, want.match_offset);
         end
      end
   end

   initial begin : result_sink
      int pause;
      forever begin
         if (long_hold > 0) begin
            pause = long_hold;
            long_hold = 0;
         end else begin
            pause = sink_always_ready ? 0 : $urandom_range(0, 8);
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && long_hold == 0);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = source_no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {value, last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (match_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index <= REG_PATTERN_5) pattern_regs[index - REG_PATTERN_0] = value;
      else if (index == REG_CARE_MASK) care_bits = value[CARE_REG_BITS-1:0];
      else if (index == REG_PATTERN_LENGTH) scan_length = value[LENGTH_REG_BITS-1:0];
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_region(input logic [7:0] bytes [$]);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic test_reset_state();
      send_region('{8'h00, 8'hFF, 8'h5A});
      send_region('{8'hFF});
      wait_idle();
   endtask

   task automatic test_overlap_and_short_regions();
      csr_write(REG_PATTERN_0, 64'h0000_0000_00FF_AAAA);
      csr_write(REG_CARE_MASK, 64'hF);
      csr_write(REG_PATTERN_LENGTH, 64'd4);
      csr_release();
      send_region('{8'hAA, 8'hAA, 8'hAA, 8'hFF, 8'h00, 8'h55});
      wait_idle();
      csr_write(REG_PATTERN_0, 64'h0);
      csr_release();
      send_region('{8'h00, 8'h00, 8'h00});
      send_region('{8'h00, 8'h00, 8'h00, 8'h00});
      wait_idle();
   endtask

   task automatic test_length_limits_and_wildcards();
      csr_write(REG_PATTERN_0, 64'hFF);
      csr_write(REG_CARE_MASK, 64'h1);
      csr_write(REG_PATTERN_LENGTH, 64'd0);
      csr_release();
      send_region('{8'h00, 8'hFF});
      wait_idle();
      csr_write(REG_PATTERN_0, 64'h0055_00AA);
      csr_write(REG_CARE_MASK, 64'h5);
      csr_write(REG_PATTERN_LENGTH, 64'd3);
      csr_release();
      send_region('{8'hAA, 8'hAA, 8'h12, 8'h55});
      wait_idle();
   endtask

   function automatic logic [7:0] noise_byte(int eff_len);
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return pattern_byte($urandom_range(0, eff_len - 1));
   endfunction

   task automatic randomize_config();
      logic [63:0] junk;
      logic [CARE_REG_BITS-1:0] care_value;
      logic [LENGTH_REG_BITS-1:0] len_value;
      for (int i = 0; i < NUM_PAT_REGS; i++) begin
         case ($urandom_range(0, 5))
            0: csr_write(REG_PATTERN_0 + CSR_INDEX_BITS'(i), '0);
            1: csr_write(REG_PATTERN_0 + CSR_INDEX_BITS'(i), '1);
            default: csr_write(REG_PATTERN_0 + CSR_INDEX_BITS'(i), {$urandom, $urandom});
         endcase
      end
      junk = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: care_value = '1;
         1: care_value = '0;
         2: care_value = junk[CARE_REG_BITS-1:0];
         default: care_value = ~(48'd1 << $urandom_range(0, 47));
      endcase
      csr_write(REG_CARE_MASK, {junk[63:CARE_REG_BITS], care_value});
      case ($urandom_range(0, 9))
         0: len_value = 6'd48;
         1: len_value = 6'd0;
         2: len_value = 6'($urandom_range(49, 63));
         3: len_value = 6'($urandom_range(9, 47));
         default: len_value = 6'($urandom_range(1, 8));
      endcase
      junk = {$urandom, $urandom};
      csr_write(REG_PATTERN_LENGTH, {junk[63:LENGTH_REG_BITS], len_value});
      csr_release();
   endtask

   task automatic test_random_regions();
      int bytes_sent;
      int eff_len;
      int regions;
      int corrupt_at;
      int prefix_len;
      logic [7:0] value;
      logic [7:0] region [$];
      bytes_sent = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         randomize_config();
         source_no_gaps = ($urandom_range(0, 3) == 0);
         sink_always_ready = ($urandom_range(0, 3) == 0);
         eff_len = effective_length();
         regions = (eff_len > 16) ? $urandom_range(1, 2) : $urandom_range(2, 5);
         repeat (regions) begin
            region.delete();
            repeat ($urandom_range(0, (eff_len > 16) ? 4 : 6))
               region.push_back(noise_byte(eff_len));
            if ($urandom_range(0, 3) != 0) begin
               if (eff_len > 1 && $urandom_range(0, 2) == 0) begin
                  prefix_len = $urandom_range(1, eff_len - 1);
                  for (int j = 0; j < prefix_len; j++) region.push_back(pattern_byte(j));
               end
               corrupt_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff_len - 1) : -1;
               for (int j = 0; j < eff_len; j++) begin
                  value = care_bits[j] ? pattern_byte(j) : 8'($urandom_range(0, 255));
                  if (j == corrupt_at) value = value ^ 8'($urandom_range(1, 255));
                  region.push_back(value);
               end
            end
            repeat ($urandom_range(0, 4)) region.push_back(noise_byte(eff_len));
            if (region.size() == 0) region.push_back(noise_byte(eff_len));
            send_region(region);
            bytes_sent += region.size();
         end
         wait_idle();
      end
      source_no_gaps = 1'b0;
      sink_always_ready = 1'b0;
   endtask

   task automatic test_output_backpressure();
      csr_write(REG_CARE_MASK, 64'h0);
      csr_write(REG_PATTERN_LENGTH, 64'd1);
      csr_release();
      source_no_gaps = 1'b1;
      long_hold = LONG_HOLD_CYCLES;
      repeat (64) send_byte(8'($urandom_range(0, 255)), 1'b1);
      source_no_gaps = 1'b0;
      wait_idle();
   endtask

   initial begin : test_sequence
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_overlap_and_short_regions();
      test_length_limits_and_wildcards();
      test_random_regions();
      test_output_backpressure();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : run_limit
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
